// ===== src/dbtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth buffer test and update: shared types and constants
// Request and result payloads, the internal command word and the register map.
// ----------------------------------------------------------------------------
package dbtu_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SPAN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DEPTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DEPTH = 8'd3;

    // Field widths
    localparam int DIM_W   = 9;
    localparam int POS_W   = 8;
    localparam int FDEPTH_W = 24;
    // Linear index y*span+x with 8-bit x, y and 9-bit span stays below 2^17.
    localparam int IDX_W   = 17;
    localparam int LIMIT_W = 2 * DIM_W;

    localparam logic [DIM_W-1:0]    ROW_SPAN_RESET    = 9'd256;
    localparam logic [DIM_W-1:0]    ROW_COUNT_RESET   = 9'd256;
    localparam logic [FDEPTH_W-1:0] NEAR_DEPTH_RESET  = 24'd0;
    localparam logic [FDEPTH_W-1:0] CLEAR_DEPTH_RESET = 24'hFFFFFF;

    localparam logic OP_TEST  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [FDEPTH_W-1:0] frag_depth;
    } t_item;

    typedef struct packed {
        logic passed;
        logic cleared;
    } t_result;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic                is_clear;
        logic                ok;
        logic [IDX_W-1:0]    idx;
        logic [FDEPTH_W-1:0] depth;
    } t_cmd;

endpackage

// ===== src/dbtu_front.sv =====
// ----------------------------------------------------------------------------
// Depth buffer front end
// Holds the configuration registers, classifies each request (near plane and
// viewport range checks, linear index) and queues it for the back end.
// ----------------------------------------------------------------------------
module dbtu_front
    import dbtu_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_init_busy,
    output t_cmd                  o_cmd,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_pop,
    output logic [FDEPTH_W-1:0]   o_clear_depth
);

    localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;

    logic [DIM_W-1:0]    r_row_span;
    logic [DIM_W-1:0]    r_row_count;
    logic [FDEPTH_W-1:0] r_near_depth;
    logic [FDEPTH_W-1:0] r_clear_depth;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic [DIM_W-1:0]   span;
    logic [DIM_W-1:0]   rows;
    logic [IDX_W-1:0]   idx;
    logic [LIMIT_W-1:0] limit;
    logic               in_range;
    logic               near_ok;
    logic               accept;
    t_cmd               cmd_new;

    assign o_cfg_ready   = 1'b1;
    assign o_clear_depth = r_clear_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_span    <= ROW_SPAN_RESET;
            r_row_count   <= ROW_COUNT_RESET;
            r_near_depth  <= NEAR_DEPTH_RESET;
            r_clear_depth <= CLEAR_DEPTH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_SPAN:    r_row_span    <= i_cfg_data[DIM_W-1:0];
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[DIM_W-1:0];
                CFG_NEAR_DEPTH:  r_near_depth  <= i_cfg_data[FDEPTH_W-1:0];
                CFG_CLEAR_DEPTH: r_clear_depth <= i_cfg_data[FDEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        span = (32'(r_row_span) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_row_span;
        rows = (32'(r_row_count) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_row_count;
        idx  = IDX_W'(IDX_W'(i_item.pos_y) * IDX_W'(span) + IDX_W'(i_item.pos_x));
        limit = LIMIT_W'(LIMIT_W'(span) * LIMIT_W'(rows));
        in_range = (LIMIT_W'(idx) < limit) && (32'(idx) < 32'(StoreSize));
        near_ok  = !(DEPTH_BITS'(i_item.frag_depth) < DEPTH_BITS'(r_near_depth));

        cmd_new.is_clear = (i_item.operation == OP_CLEAR);
        cmd_new.ok       = in_range && near_ok;
        cmd_new.idx      = idx;
        cmd_new.depth    = i_item.frag_depth;
    end

    // Requests are held off while the back end runs its power-up sweep.
    assign full        = (r_count == 2'd2) || i_init_busy;
    assign accept      = push && !full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cmd_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({accept, i_cmd_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/dbtu_back.sv =====
// ----------------------------------------------------------------------------
// Depth buffer back end
// Owns the depth memory, runs the read-compare-write of a depth test and the
// clear sweeps, and queues the results.
// ----------------------------------------------------------------------------
module dbtu_back
    import dbtu_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  logic [FDEPTH_W-1:0] i_clear_depth,
    output logic                o_init_busy,
    output t_result             o_result,
    output logic                empty,
    input  logic                pop
);

    localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;
    localparam int AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
    localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreSize - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_CLEAR
    } t_state;

    logic [DEPTH_BITS-1:0] r_mem [StoreSize];
    logic [DEPTH_BITS-1:0] r_rd_data;

    t_state           r_state;
    t_cmd             r_cur;
    logic [AddrW-1:0] r_cursor;

    t_result    r_res_q [2];
    logic       r_res_wr;
    logic       r_res_rd;
    logic [1:0] r_res_count;

    logic                  res_room;
    logic                  res_push;
    logic                  res_pop;
    t_result               res_data;
    logic [DEPTH_BITS-1:0] cur_depth;
    logic [AddrW-1:0]      cur_addr;
    logic                  hit;
    logic                  mem_we;
    logic [AddrW-1:0]      mem_waddr;
    logic [DEPTH_BITS-1:0] mem_wdata;
    logic                  sweep_last;

    assign res_room    = (r_res_count != 2'd2);
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && res_room;
    assign o_init_busy = (r_state == S_INIT);
    assign cur_depth   = DEPTH_BITS'(r_cur.depth);
    assign cur_addr    = AddrW'(r_cur.idx);
    assign hit         = cur_depth < r_rd_data;
    assign sweep_last  = (r_cursor == LastAddr);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cursor;
        mem_wdata = DEPTH_BITS'(i_clear_depth);
        res_push  = 1'b0;
        res_data  = '0;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = DEPTH_BITS'(CLEAR_DEPTH_RESET);
            end
            S_IDLE: begin
                // A test that fails the range or near check never touches memory.
                if (o_cmd_pop && !i_cmd.is_clear && !i_cmd.ok) begin
                    res_push = 1'b1;
                end
            end
            S_CHECK: begin
                mem_we          = hit;
                mem_waddr       = cur_addr;
                mem_wdata       = cur_depth;
                res_push        = 1'b1;
                res_data.passed = hit;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                if (sweep_last) begin
                    res_push         = 1'b1;
                    res_data.cleared = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cursor <= '0;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (sweep_last) begin
                        r_cursor <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cursor <= r_cursor + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cur <= i_cmd;
                        if (i_cmd.is_clear) begin
                            r_cursor <= '0;
                            r_state  <= S_CLEAR;
                        end else if (i_cmd.ok) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    if (sweep_last) begin
                        r_cursor <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cursor <= r_cursor + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign res_pop  = pop && !empty;
    assign empty    = (r_res_count == 2'd0);
    assign o_result = r_res_q[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_q[r_res_wr] <= res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr    <= 1'b0;
            r_res_rd    <= 1'b0;
            r_res_count <= 2'd0;
        end else begin
            if (res_push) begin
                r_res_wr <= !r_res_wr;
            end
            if (res_pop) begin
                r_res_rd <= !r_res_rd;
            end
            case ({res_push, res_pop})
                2'b10:   r_res_count <= r_res_count + 2'd1;
                2'b01:   r_res_count <= r_res_count - 2'd1;
                default: r_res_count <= r_res_count;
            endcase
        end
    end

endmodule

// ===== src/depth_buffer_test_update_core.sv =====
// ----------------------------------------------------------------------------
// Depth buffer test and update core
// Strict less-than depth test against a single-port depth memory, with clear.
// ----------------------------------------------------------------------------
// Requests queue in a two-entry buffer and are then carried out one at a time.
// A depth test inside the viewport and at or beyond the near plane goes
// through dequeue, memory read, and compare and write back, in that order,
// since the memory has a single port; a test that fails the range or near
// check gives its result at dequeue and never touches the memory. A clear
// rewrites the memory one entry per cycle. After reset a like sweep fills
// the memory with the far depth; full stays high while it runs, and
// configuration writes are taken as usual. Every request gives exactly one
// result.
module depth_buffer_test_update_core
    import dbtu_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd                cmd;
    logic                cmd_valid;
    logic                cmd_pop;
    logic                init_busy;
    logic [FDEPTH_W-1:0] clear_depth;

    dbtu_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_init_busy   (init_busy),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop),
        .o_clear_depth (clear_depth)
    );

    dbtu_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .i_clear_depth (clear_depth),
        .o_init_busy   (init_busy),
        .o_result      (o_result),
        .empty         (empty),
        .pop           (pop)
    );

endmodule
